// ===== design/kpl_pkg.sv =====
// Shared types, token codes and keyword tables for the keyword prefix lexer.
`default_nettype none

package kpl_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_INT   = 3'd1,
		MODE_IDENT = 3'd2,
		MODE_KW    = 3'd3,
		MODE_ERR   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_WAIT  = 2'd0,
		ST_FLUSH = 2'd1,
		ST_CLOSE = 2'd2,
		ST_FINAL = 2'd3
	} state_t;

	typedef enum logic [1:0] {
		SEL_FLUSH = 2'd0,
		SEL_CLOSE = 2'd1,
		SEL_FINAL = 2'd2
	} sel_t;

	localparam logic [4:0] KIND_INT   = 5'd0;
	localparam logic [4:0] KIND_IDENT = 5'd1;
	localparam logic [4:0] KIND_IF    = 5'd2;
	localparam logic [4:0] KIND_HASH  = 5'd9;
	localparam logic [4:0] KIND_PLUS  = 5'd10;
	localparam logic [4:0] KIND_MINUS = 5'd11;
	localparam logic [4:0] KIND_EQ    = 5'd12;
	localparam logic [4:0] KIND_GT    = 5'd13;
	localparam logic [4:0] KIND_SEMI  = 5'd14;
	localparam logic [4:0] KIND_EOF   = 5'd15;
	localparam logic [4:0] KIND_ERROR = 5'd16;

	localparam int NUM_KW = 7;
	localparam int PEND_DEPTH = 4;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic emit;
		sel_t sel;
		logic flush_adv;
		logic commit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic flush_req;
		logic flush_last;
		logic close_req;
		logic final_req;
		logic out_free;
	} status_t;

	// keyword text, first letter in the top byte, zero padded
	function automatic logic [39:0] kw_word(input logic [2:0] k);
		logic [39:0] w;
		case (k)
			3'd0:    w = {"if", 24'h0};
			3'd1:    w = {"then", 8'h0};
			3'd2:    w = {"else", 8'h0};
			3'd3:    w = "while";
			3'd4:    w = {"do", 24'h0};
			3'd5:    w = {"true", 8'h0};
			3'd6:    w = "false";
			default: w = 40'h0;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] kw_len(input logic [2:0] k);
		logic [2:0] n;
		case (k)
			3'd0, 3'd4:       n = 3'd2;
			3'd1, 3'd2, 3'd5: n = 3'd4;
			3'd3, 3'd6:       n = 3'd5;
			default:          n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
		logic [39:0] w;
		logic [7:0]  ch;
		w = kw_word(k);
		case (pos)
			3'd0:    ch = w[39:32];
			3'd1:    ch = w[31:24];
			3'd2:    ch = w[23:16];
			3'd3:    ch = w[15:8];
			3'd4:    ch = w[7:0];
			default: ch = 8'h0;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== design/kpl_ctrl.sv =====
// Sequencer: steps each captured character through flush, close and final result phases.
`default_nettype none

module kpl_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  wire kpl_pkg::status_t st,
	output kpl_pkg::cmd_t    cmd
);
	import kpl_pkg::*;

	state_t state_q, state_d, ph;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.sel  = SEL_FINAL;
		in_ready = 1'b0;
		// skip phases with nothing to send in the same cycle
		ph = state_q;
		if (ph == ST_FLUSH && !st.flush_req) ph = ST_CLOSE;
		if (ph == ST_CLOSE && !st.close_req) ph = ST_FINAL;
		case (ph)
			ST_WAIT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.sel       = SEL_FLUSH;
					cmd.flush_adv = 1'b1;
					if (st.flush_last) state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_CLOSE;
					state_d  = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (!st.final_req) begin
					cmd.commit = 1'b1;
					state_d    = ST_WAIT;
				end else if (st.out_free) begin
					cmd.emit   = 1'b1;
					cmd.sel    = SEL_FINAL;
					cmd.commit = 1'b1;
					state_d    = ST_WAIT;
				end
			end
			default: state_d = ST_WAIT;
		endcase
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result loaded into occupied output register");

	a_commit_returns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == ST_WAIT)
		else $error("sequencer did not return to wait after commit");

	a_commit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (state_q != ST_WAIT) && !cmd.capture)
		else $error("commit while waiting for input");

endmodule

`default_nettype wire

// ===== design/kpl_dp.sv =====
// Datapath: scan state, held letters, keyword match, result decode and output register.
`default_nettype none

module kpl_dp (
	input  wire              clk,
	input  wire              arst_n,
	input  wire  [7:0]       in_char,
	input  wire              in_eoi,
	input  wire kpl_pkg::cmd_t cmd,
	output kpl_pkg::status_t st,
	input  wire              out_ready,
	output logic             out_valid,
	output logic [4:0]       out_kind,
	output logic [7:0]       out_text,
	output logic             out_end,
	output logic             out_last
);
	import kpl_pkg::*;

	// captured item
	logic [7:0] char_q;
	logic       eoi_q;
	// scan state
	mode_t      mode_q;
	logic [2:0] cnt_q;
	logic [NUM_KW-1:0] cands_q;
	logic [7:0] pend_q [PEND_DEPTH];
	logic [1:0] fidx_q;
	// output register
	logic       valid_q;
	logic [4:0] kind_q;
	logic [7:0] text_q;
	logic       end_q;
	logic       last_q;

	// decode
	logic       let_c, dig_c;
	logic [2:0] kw_pos;
	logic [NUM_KW-1:0] kw_cands, kw_mask;
	logic       kw_done;
	logic [2:0] kw_k;
	logic       so_req;
	logic [4:0] so_kind;
	logic [7:0] so_text;
	logic       so_end;
	mode_t      so_mode;
	logic       flush_req, close_req, final_req, store;
	logic [4:0] close_kind, final_kind;
	logic [7:0] final_text;
	logic       final_end;
	mode_t      nx_mode;
	logic [2:0] nx_cnt;
	logic [NUM_KW-1:0] nx_cands;
	logic       flush_last;

	assign let_c = (char_q >= "a" && char_q <= "z") || (char_q >= "A" && char_q <= "Z");
	assign dig_c = (char_q >= "0" && char_q <= "9");

	// handling of a non-letter at a token start
	always_comb begin
		so_req  = 1'b1;
		so_kind = KIND_ERROR;
		so_text = 8'h0;
		so_end  = 1'b1;
		so_mode = MODE_IDLE;
		if (char_q == " ") begin
			so_req = 1'b0;
		end else if (dig_c) begin
			so_kind = KIND_INT;
			so_text = char_q;
			so_end  = 1'b0;
			so_mode = MODE_INT;
		end else begin
			case (char_q)
				"#":     so_kind = KIND_HASH;
				"+":     so_kind = KIND_PLUS;
				"-":     so_kind = KIND_MINUS;
				"=":     so_kind = KIND_EQ;
				">":     so_kind = KIND_GT;
				";":     so_kind = KIND_SEMI;
				default: so_mode = MODE_ERR;
			endcase
		end
	end

	// keyword prefix step, lowest keyword wins on completion
	always_comb begin
		kw_pos   = (mode_q == MODE_KW) ? cnt_q : 3'd0;
		kw_cands = (mode_q == MODE_KW) ? cands_q : '1;
		kw_mask  = '0;
		kw_done  = 1'b0;
		kw_k     = 3'd0;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (kw_cands[k] && kw_pos < kw_len(3'(k)) && kw_char(3'(k), kw_pos) == char_q) begin
				if (kw_pos + 3'd1 == kw_len(3'(k))) begin
					kw_done = 1'b1;
					kw_k    = 3'(k);
				end else begin
					kw_mask[k] = 1'b1;
				end
			end
		end
	end

	// what this item sends and what it leaves behind
	always_comb begin
		flush_req  = 1'b0;
		close_req  = 1'b0;
		close_kind = KIND_INT;
		final_req  = 1'b0;
		final_kind = KIND_INT;
		final_text = 8'h0;
		final_end  = 1'b1;
		store      = 1'b0;
		nx_mode    = mode_q;
		nx_cnt     = cnt_q;
		nx_cands   = cands_q;
		if (mode_q == MODE_ERR) begin
			if (eoi_q) begin
				nx_mode  = MODE_IDLE;
				nx_cnt   = 3'd0;
				nx_cands = '0;
			end
		end else if (eoi_q) begin
			flush_req  = (mode_q == MODE_KW);
			close_req  = (mode_q != MODE_IDLE);
			close_kind = (mode_q == MODE_INT) ? KIND_INT : KIND_IDENT;
			final_req  = 1'b1;
			final_kind = KIND_EOF;
			nx_mode    = MODE_IDLE;
			nx_cnt     = 3'd0;
			nx_cands   = '0;
		end else begin
			if (mode_q == MODE_INT && !dig_c) begin
				close_req  = 1'b1;
				close_kind = KIND_INT;
			end
			if (mode_q == MODE_IDENT && !let_c) begin
				close_req  = 1'b1;
				close_kind = KIND_IDENT;
			end
			if (mode_q == MODE_INT && dig_c) begin
				final_req  = 1'b1;
				final_kind = KIND_INT;
				final_text = char_q;
				final_end  = 1'b0;
			end else if (mode_q == MODE_IDENT && let_c) begin
				final_req  = 1'b1;
				final_kind = KIND_IDENT;
				final_text = char_q;
				final_end  = 1'b0;
			end else if (mode_q == MODE_KW ||
			             (let_c && (mode_q == MODE_IDLE || mode_q == MODE_INT))) begin
				if (kw_done) begin
					final_req  = 1'b1;
					final_kind = 5'(KIND_IF + {2'b00, kw_k});
					nx_mode    = MODE_IDLE;
					nx_cnt     = 3'd0;
					nx_cands   = '0;
				end else if (kw_mask != '0 && kw_pos < 3'(PEND_DEPTH)) begin
					store    = 1'b1;
					nx_mode  = MODE_KW;
					nx_cnt   = kw_pos + 3'd1;
					nx_cands = kw_mask;
				end else begin
					// prefix broken: held letters become identifier text
					flush_req = (mode_q == MODE_KW);
					nx_cnt    = 3'd0;
					nx_cands  = '0;
					if (let_c) begin
						final_req  = 1'b1;
						final_kind = KIND_IDENT;
						final_text = char_q;
						final_end  = 1'b0;
						nx_mode    = MODE_IDENT;
					end else begin
						close_req  = 1'b1;
						close_kind = KIND_IDENT;
						final_req  = so_req;
						final_kind = so_kind;
						final_text = so_text;
						final_end  = so_end;
						nx_mode    = so_mode;
					end
				end
			end else begin
				final_req  = so_req;
				final_kind = so_kind;
				final_text = so_text;
				final_end  = so_end;
				nx_mode    = so_mode;
			end
		end
	end

	assign flush_last    = ({1'b0, fidx_q} + 3'd1) == cnt_q;
	assign st.flush_req  = flush_req && (cnt_q != 3'd0);
	assign st.flush_last = flush_last;
	assign st.close_req  = close_req;
	assign st.final_req  = final_req;
	assign st.out_free   = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			cnt_q   <= 3'd0;
			cands_q <= '0;
			fidx_q  <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.capture) fidx_q <= 2'd0;
			else if (cmd.flush_adv) fidx_q <= fidx_q + 2'd1;
			if (cmd.commit) begin
				mode_q  <= nx_mode;
				cnt_q   <= nx_cnt;
				cands_q <= nx_cands;
			end
			if (cmd.emit) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			char_q <= in_char;
			eoi_q  <= in_eoi;
		end
		if (cmd.commit && store) pend_q[kw_pos[1:0]] <= char_q;
		if (cmd.emit) begin
			case (cmd.sel)
				SEL_FLUSH: begin
					kind_q <= KIND_IDENT;
					text_q <= pend_q[fidx_q];
					end_q  <= 1'b0;
					last_q <= flush_last && !close_req && !final_req;
				end
				SEL_CLOSE: begin
					kind_q <= close_kind;
					text_q <= 8'h0;
					end_q  <= 1'b1;
					last_q <= !final_req;
				end
				default: begin
					kind_q <= final_kind;
					text_q <= final_text;
					end_q  <= final_end;
					last_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_text  = text_q;
	assign out_end   = end_q;
	assign out_last  = last_q;

	a_kw_held: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_KW |-> cnt_q != 3'd0 && cnt_q <= 3'(PEND_DEPTH) && cands_q != '0)
		else $error("keyword mode without held letters or candidates");

	a_no_kw_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_KW |-> cnt_q == 3'd0 && cands_q == '0)
		else $error("held letters outside keyword mode");

	a_flush_in_kw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.sel == SEL_FLUSH |-> mode_q == MODE_KW)
		else $error("letter flush outside keyword mode");

endmodule

`default_nettype wire

// ===== design/keyword_prefix_lexer.sv =====
// Top level of the keyword prefix lexer: stream ports, sequencer and datapath.
`default_nettype none

// Character-at-a-time lexer. Each input transfer carries one ASCII character in
// s_axis_tdata, or an end-of-input marker in s_axis_tuser (the character is then
// ignored). Digit runs become integer tokens and letter runs identifiers, each sent
// one character per output transfer and followed by a closing transfer with
// token_end set. Letters at a token start are matched as a prefix against if, then,
// else, while, do, true and false; a keyword token is sent as soon as its last
// letter arrives, with no word boundary check. While the match is open, up to four
// letters are held; when it breaks they are sent as identifier text. Space
// separates tokens, # + - = > ; are single-character tokens, any other code gives
// an error token and the rest of the input up to end of input is dropped. End of
// input flushes pending text and sends an end-of-file token, but after an error it
// sends nothing. m_axis_tlast marks the final output transfer of each input transfer.
// Flow: the sequencer takes one input transfer, then sends its results one per
// cycle through a single output register, except while m_axis_tready holds that
// register full. The next input is accepted while the last result still waits.
module keyword_prefix_lexer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] in_char
	input  wire  [0:0]  s_axis_tuser,   // [0] end_of_input
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] text_char, [8] token_end, [15:9] zero
	output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
	output logic        m_axis_tlast    // last
);
	import kpl_pkg::*;

	cmd_t       cmd;
	status_t    st;
	logic [7:0] text;
	logic       tok_end;

	// sequencer decides which result goes out each cycle
	kpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// scan state, keyword match and output register
	kpl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_char   (s_axis_tdata),
		.in_eoi    (s_axis_tuser[0]),
		.cmd       (cmd),
		.st        (st),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_kind  (m_axis_tuser),
		.out_text  (text),
		.out_end   (tok_end),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, tok_end, text};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking keyword_prefix_lexer testbench: directed and random streams checked against a token predictor.
`default_nettype none

module testbench;
	import kpl_pkg::*;

	typedef struct packed {
		logic [4:0] kind;
		logic [7:0] text;
		logic       tend;
		logic       last;
	} token_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
		logic       drain;  // hold this one back until every token so far has come out
	} char_item_t;

	localparam int N_DIRECTED  = 27;
	localparam int N_RANDOM    = 150;
	localparam int HOLDOFF_LEN = 250;
	localparam int IDLE_LIMIT  = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        ch_valid = 1'b0;
	logic [7:0]  ch_data = 8'd0;
	logic [0:0]  ch_eoi = 1'b0;
	logic        tok_ready = 1'b0;
	wire         s_axis_tready;
	wire         m_axis_tvalid;
	wire  [15:0] m_axis_tdata;
	wire  [4:0]  m_axis_tuser;
	wire         m_axis_tlast;

	keyword_prefix_lexer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (ch_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (ch_data),      // [7:0] in_char
		.s_axis_tuser  (ch_eoi),       // [0] end_of_input
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (tok_ready),
		.m_axis_tdata  (m_axis_tdata), // [7:0] text_char, [8] token_end
		.m_axis_tuser  (m_axis_tuser), // [4:0] token_kind
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Token predictor
	// ------------------------------------------------------------------
	string kw_names [7] = '{"if", "then", "else", "while", "do", "true", "false"};

	token_t     token_due_q [$];
	char_item_t char_feed_q [$];

	mode_t       scan_state = MODE_IDLE;
	logic [7:0]  held_chars [4];
	int unsigned held_cnt = 0;
	logic [6:0]  kw_alive = 7'h0;

	int errors = 0;
	int n_sent = 0;
	int n_tokens = 0;
	int n_kw = 0;
	int n_err_tok = 0;

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void push_token(logic [4:0] kind, logic [7:0] text, logic tend);
		token_t t;
		t.kind = kind;
		t.text = text;
		t.tend = tend;
		t.last = 1'b0;
		token_due_q.insert(token_due_q.size(), t);
	endfunction

	function automatic void lex_reset();
		scan_state = MODE_IDLE;
		held_cnt = 0;
		kw_alive = 7'h0;
	endfunction

	// non-letter at a token start
	function automatic void lex_other(logic [7:0] c);
		scan_state = MODE_IDLE;
		if (c == " ")
			return;
		if (is_num(c)) begin
			scan_state = MODE_INT;
			push_token(KIND_INT, c, 1'b0);
			return;
		end
		case (c)
			"#": push_token(KIND_HASH, 8'd0, 1'b1);
			"+": push_token(KIND_PLUS, 8'd0, 1'b1);
			"-": push_token(KIND_MINUS, 8'd0, 1'b1);
			"=": push_token(KIND_EQ, 8'd0, 1'b1);
			">": push_token(KIND_GT, 8'd0, 1'b1);
			";": push_token(KIND_SEMI, 8'd0, 1'b1);
			default: begin
				scan_state = MODE_ERR;
				push_token(KIND_ERROR, 8'd0, 1'b1);
			end
		endcase
	endfunction

	function automatic void flush_held();
		int unsigned i;
		for (i = 0; i < held_cnt && i < 4; i++)
			push_token(KIND_IDENT, held_chars[i], 1'b0);
		held_cnt = 0;
		kw_alive = 7'h0;
	endfunction

	// one step of the keyword prefix match
	function automatic void kw_advance(logic [7:0] c);
		int unsigned pos;
		logic [6:0]  hit;
		int          k;
		pos = held_cnt;
		hit = 7'h0;
		for (k = 0; k < 7; k++) begin
			if (kw_alive[k] && pos < kw_names[k].len() && kw_names[k][pos] == c) begin
				if (pos + 1 == kw_names[k].len()) begin
					lex_reset();
					push_token(KIND_IF + 5'(k), 8'd0, 1'b1);
					return;
				end
				hit[k] = 1'b1;
			end
		end
		if (hit != 7'h0 && pos < 4) begin
			held_chars[pos] = c;
			held_cnt = pos + 1;
			kw_alive = hit;
			scan_state = MODE_KW;
			return;
		end
		flush_held();
		if (is_alpha(c)) begin
			// broken by a letter: held text carries on as one identifier
			scan_state = MODE_IDENT;
			push_token(KIND_IDENT, c, 1'b0);
			return;
		end
		push_token(KIND_IDENT, 8'd0, 1'b1);
		lex_other(c);
	endfunction

	function automatic void lex_start(logic [7:0] c);
		if (is_alpha(c)) begin
			held_cnt = 0;
			kw_alive = 7'h7f;
			scan_state = MODE_KW;
			kw_advance(c);
		end else begin
			lex_other(c);
		end
	endfunction

	function automatic void lex_char(logic [7:0] c, logic eoi);
		int unsigned base;
		base = token_due_q.size();
		if (scan_state == MODE_ERR) begin
			// everything dropped until end of input
			if (eoi)
				lex_reset();
			return;
		end
		if (eoi) begin
			case (scan_state)
				MODE_KW: begin
					flush_held();
					push_token(KIND_IDENT, 8'd0, 1'b1);
				end
				MODE_INT:   push_token(KIND_INT, 8'd0, 1'b1);
				MODE_IDENT: push_token(KIND_IDENT, 8'd0, 1'b1);
				default: ;
			endcase
			push_token(KIND_EOF, 8'd0, 1'b1);
			lex_reset();
		end else begin
			case (scan_state)
				MODE_INT: begin
					if (is_num(c)) begin
						push_token(KIND_INT, c, 1'b0);
					end else begin
						push_token(KIND_INT, 8'd0, 1'b1);
						lex_start(c);
					end
				end
				MODE_IDENT: begin
					if (is_alpha(c)) begin
						push_token(KIND_IDENT, c, 1'b0);
					end else begin
						push_token(KIND_IDENT, 8'd0, 1'b1);
						lex_start(c);
					end
				end
				MODE_KW: kw_advance(c);
				default: lex_start(c);
			endcase
		end
		if (token_due_q.size() > base)
			token_due_q[token_due_q.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------
	int stim_count = 0;
	bit drain_next = 1'b0;

	task automatic add_char(logic [7:0] c);
		char_item_t it;
		it.ch = c;
		it.eoi = 1'b0;
		it.drain = drain_next;
		drain_next = 1'b0;
		char_feed_q.insert(char_feed_q.size(), it);
		stim_count++;
	endtask

	task automatic add_eoi();
		char_item_t it;
		it.ch = 8'($urandom_range(0, 255));
		it.eoi = 1'b1;
		it.drain = drain_next;
		drain_next = 1'b0;
		char_feed_q.insert(char_feed_q.size(), it);
		stim_count++;
	endtask

	task automatic add_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_symbol();
		string syms;
		syms = "#+-=>;";
		return syms[$urandom_range(0, 5)];
	endfunction

	// A short source line of mostly well-formed tokens, closed by end of input.
	task automatic add_random_program();
		int         ntok;
		int         len;
		int         j;
		string      w;
		logic [7:0] c;
		char_item_t junk;
		ntok = $urandom_range(1, 8);
		repeat (ntok) begin
			case ($urandom_range(0, 9))
				0, 1: add_text(kw_names[$urandom_range(0, 6)]);
				2: begin
					// keyword cut short, then whatever breaks it
					w = kw_names[$urandom_range(0, 6)];
					len = $urandom_range(1, w.len() - 1);
					add_text(w.substr(0, len - 1));
					case ($urandom_range(0, 3))
						0: add_char(rand_letter());
						1: add_char(8'("0") + 8'($urandom_range(0, 9)));
						2: add_char(rand_symbol());
						default: add_char(" ");
					endcase
				end
				3, 4: begin
					len = $urandom_range(1, 8);
					for (j = 0; j < len; j++)
						add_char(rand_letter());
				end
				5, 6: begin
					len = $urandom_range(1, 6);
					for (j = 0; j < len; j++)
						add_char(8'("0") + 8'($urandom_range(0, 9)));
				end
				7: add_char(rand_symbol());
				8: add_char(" ");
				default: begin
					c = 8'($urandom_range(0, 255));
					add_char(c);
					if (!(is_alpha(c) || is_num(c) || c == " " || c == "#" || c == "+" ||
					      c == "-" || c == "=" || c == ">" || c == ";")) begin
						// error state: up to two dropped characters, then end of input
						repeat ($urandom_range(0, 2)) begin
							junk.ch = 8'($urandom_range(0, 255));
							junk.eoi = 1'b0;
							junk.drain = 1'b0;
							char_feed_q.insert(char_feed_q.size(), junk);
						end
						add_eoi();
						return;
					end
				end
			endcase
			if ($urandom_range(0, 2) == 0)
				add_char(" ");
		end
		add_eoi();
	endtask

	// ------------------------------------------------------------------
	// Character driver: bursts with random gaps
	// ------------------------------------------------------------------
	int         burst_left = 0;
	int         gap_left = 0;
	char_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_valid <= 1'b0;
			ch_data <= 8'd0;
			ch_eoi <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (ch_valid && s_axis_tready) begin
				lex_char(ch_data, ch_eoi[0]);
				n_sent++;
			end
			if (!ch_valid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					ch_valid <= 1'b0;
				end else if (char_feed_q.size() != 0 &&
				             !(char_feed_q[0].drain && token_due_q.size() != 0)) begin
					next_item = char_feed_q.pop_front();
					ch_valid <= 1'b1;
					ch_data <= next_item.ch;
					ch_eoi <= next_item.eoi;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					ch_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Token monitor and receiver stall pattern
	// ------------------------------------------------------------------
	token_t want;
	int     hold_left = 0;
	bit     held_once = 1'b0;
	int     phase_left = 0;
	int     stall_pct = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ready <= 1'b0;
		end else begin
			if (m_axis_tvalid && tok_ready) begin
				n_tokens++;
				if (m_axis_tuser >= KIND_IF && m_axis_tuser < KIND_HASH)
					n_kw++;
				if (m_axis_tuser == KIND_ERROR)
					n_err_tok++;
				if (token_due_q.size() == 0) begin
					$error("unexpected token: kind %0d text %0h", m_axis_tuser,
					       m_axis_tdata[7:0]);
					errors++;
				end else begin
					want = token_due_q.pop_front();
					if (m_axis_tuser !== want.kind) begin
						$error("token_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[7:0] !== want.text) begin
						$error("text_char: expected %0h, got %0h", want.text, m_axis_tdata[7:0]);
						errors++;
					end
					if (m_axis_tdata[8] !== want.tend) begin
						$error("token_end: expected %0b, got %0b", want.tend, m_axis_tdata[8]);
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, m_axis_tlast);
						errors++;
					end
				end
			end
			// one long hold-off so the lexer backs up into its input
			if (hold_left != 0) begin
				hold_left--;
				tok_ready <= 1'b0;
			end else if (!held_once && n_tokens >= 40) begin
				held_once = 1'b1;
				hold_left = HOLDOFF_LEN;
				tok_ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					stall_pct = 25 * $urandom_range(0, 3);
					phase_left = $urandom_range(16, 80);
				end else begin
					phase_left--;
				end
				tok_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: cycles with no transfer on either side
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((ch_valid && s_axis_tready) || (m_axis_tvalid && tok_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d tokens still due",
				         idle_cycles, token_due_q.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		// directed: each keyword case, every symbol, digit extremes, eoi in integer, identifier, keyword and error modes
		add_text("if");        // keyword completed
		add_text("thx#");      // prefix broken by a letter, then a symbol
		add_text("el+");       // prefix broken by a non-letter
		add_text("09-=>;");
		add_text(" 7");
		add_eoi();             // end of input inside an integer
		add_text("Z");
		add_eoi();             // inside an identifier
		add_text("tru");
		add_eoi();             // with letters held
		add_char(8'hff);       // unexpected code
		add_char("a");         // dropped
		add_eoi();             // end of input after an error: no output

		drain_next = 1'b1;
		while (stim_count < N_DIRECTED + N_RANDOM) begin
			if (stim_count >= N_DIRECTED + N_RANDOM / 2 && !held_once && !drain_next)
				drain_next = 1'b1;
			add_random_program();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (char_feed_q.size() != 0 || ch_valid || token_due_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("sent %0d characters and end markers, checked %0d tokens", n_sent, n_tokens);
		$display("of which %0d keywords and %0d error tokens", n_kw, n_err_tok);
		if (errors == 0 && token_due_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
